// File: rtl/core/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

	localparam int ADC_W       = 24;
	localparam int COEF_W      = 16;
	localparam int REG_IDX_W   = 3;
	localparam int P_W         = 17;
	localparam int T_W         = 12;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	localparam int DT_W   = 25;
	localparam int NUM_W  = 42;
	localparam int OFF_W  = 36;
	localparam int SENS_W = 36;
	localparam int SPLIT  = 18;
	localparam int PL_W   = ADC_W + SPLIT;
	localparam int PH_W   = ADC_W + 1 + SPLIT;
	localparam int TQ_W   = 19;
	localparam int X_W    = 60;
	localparam int PQ_W   = 24;

	localparam int NUM_STAGES = 10;

	localparam logic [REG_IDX_W-1:0] REG_SENS_BASE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_BASE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

	localparam logic signed [NUM_W-1:0] TEMP_BASE = 42'sd16777216000;

	localparam int            DIV_BY    = 100;
	localparam int            RECIP_W   = 26;
	localparam int            DIV_SHIFT = 32;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd42949673;

	typedef logic [NUM_STAGES-1:0] stage_en_t;

	typedef struct packed {
		logic [COEF_W-1:0] sens_base;
		logic [COEF_W-1:0] offset_base;
		logic [COEF_W-1:0] sens_temp;
		logic [COEF_W-1:0] offset_temp;
		logic [COEF_W-1:0] ref_temp;
		logic [COEF_W-1:0] temp_slope;
	} coef_t;

endpackage

// File: rtl/core/bsc_front.sv
`timescale 1ns / 1ps

module bsc_front (
	input  logic                                   clk,
	input  bsc_pkg::stage_en_t                     en,
	input  bsc_pkg::coef_t                         coef,
	input  logic        [bsc_pkg::ADC_W-1:0]       d1,
	input  logic        [bsc_pkg::ADC_W-1:0]       d2,
	output logic        [bsc_pkg::ADC_W-1:0]       d1_s4,
	output logic signed [bsc_pkg::OFF_W-1:0]       off_s4,
	output logic signed [bsc_pkg::SENS_W-1:0]      sens_s4,
	output logic signed [bsc_pkg::TQ_W-1:0]        tq_s4
);
	import bsc_pkg::*;

	logic        [ADC_W-1:0] d1_s1, d1_s2, d1_s3;
	logic signed [DT_W-1:0]  dt_s1;
	logic signed [NUM_W-1:0] p_off_s2, p_sens_s2, p_temp_s2;
	logic signed [NUM_W-1:0] n_off_s3, n_sens_s3, n_temp_s3;
	logic signed [NUM_W-1:0] off_b, sens_b, temp_b;
	logic signed [COEF_W:0]  c_off, c_sens, c_temp;

	assign c_off  = $signed({1'b0, coef.offset_temp});
	assign c_sens = $signed({1'b0, coef.sens_temp});
	assign c_temp = $signed({1'b0, coef.temp_slope});

	// bias negative values so the arithmetic shift truncates toward zero
	assign off_b  = n_off_s3 + $signed({{(NUM_W-6){1'b0}}, {6{n_off_s3[NUM_W-1]}}});
	assign sens_b = n_sens_s3 + $signed({{(NUM_W-7){1'b0}}, {7{n_sens_s3[NUM_W-1]}}});
	assign temp_b = n_temp_s3 + $signed({{(NUM_W-23){1'b0}}, {23{n_temp_s3[NUM_W-1]}}});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= d1;
			dt_s1 <= $signed({1'b0, d2}) - $signed({1'b0, coef.ref_temp, 8'b0});
		end
		if (en[1]) begin
			d1_s2     <= d1_s1;
			p_off_s2  <= dt_s1 * c_off;
			p_sens_s2 <= dt_s1 * c_sens;
			p_temp_s2 <= dt_s1 * c_temp;
		end
		if (en[2]) begin
			d1_s3     <= d1_s2;
			n_off_s3  <= $signed({3'b0, coef.offset_base, 23'b0}) + p_off_s2;
			n_sens_s3 <= $signed({3'b0, coef.sens_base, 23'b0}) + p_sens_s2;
			n_temp_s3 <= TEMP_BASE + p_temp_s2;
		end
		if (en[3]) begin
			d1_s4   <= d1_s3;
			off_s4  <= OFF_W'(off_b >>> 6);
			sens_s4 <= SENS_W'(sens_b >>> 7);
			tq_s4   <= TQ_W'(temp_b >>> 23);
		end
	end

endmodule

// File: rtl/core/bsc_press.sv
`timescale 1ns / 1ps

module bsc_press (
	input  logic                                   clk,
	input  bsc_pkg::stage_en_t                     en,
	input  logic        [bsc_pkg::ADC_W-1:0]       d1_s4,
	input  logic signed [bsc_pkg::OFF_W-1:0]       off_s4,
	input  logic signed [bsc_pkg::SENS_W-1:0]      sens_s4,
	input  logic signed [bsc_pkg::TQ_W-1:0]        tq_s4,
	output logic signed [bsc_pkg::PQ_W-1:0]        pq_s8,
	output logic signed [bsc_pkg::TQ_W-1:0]        tq_s8
);
	import bsc_pkg::*;

	logic        [PL_W-1:0]  pl_s5;
	logic signed [PH_W-1:0]  ph_s5;
	logic signed [OFF_W-1:0] off_s5, off_s6;
	logic signed [X_W-1:0]   pp, pp_s6, x_s7, x_b;
	logic signed [TQ_W-1:0]  tq_s5, tq_s6, tq_s7;

	// product of d1 and sens as two partial products on the halves of sens
	assign pp = (X_W'(ph_s5) <<< SPLIT) + $signed({{(X_W-PL_W){1'b0}}, pl_s5});
	assign x_b = x_s7 + $signed({{(X_W-36){1'b0}}, {36{x_s7[X_W-1]}}});

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pl_s5  <= {{SPLIT{1'b0}}, d1_s4} * {{ADC_W{1'b0}}, sens_s4[SPLIT-1:0]};
			ph_s5  <= PH_W'($signed({1'b0, d1_s4})) *
				PH_W'($signed(sens_s4[SENS_W-1:SPLIT]));
			off_s5 <= off_s4;
			tq_s5  <= tq_s4;
		end
		if (en[5]) begin
			pp_s6  <= pp;
			off_s6 <= off_s5;
			tq_s6  <= tq_s5;
		end
		if (en[6]) begin
			x_s7  <= pp_s6 - (X_W'(off_s6) <<< 21);
			tq_s7 <= tq_s6;
		end
		if (en[7]) begin
			pq_s8 <= PQ_W'(x_b >>> 36);
			tq_s8 <= tq_s7;
		end
	end

endmodule

// File: rtl/core/bsc_div100.sv
`timescale 1ns / 1ps

module bsc_div100 #(
	parameter int IN_W  = 24,
	parameter int OUT_W = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              en,
	input  logic                    vld_a,
	input  logic signed [IN_W-1:0]  din,
	output logic signed [OUT_W-1:0] dout
);
	import bsc_pkg::*;

	localparam int PROD_W = IN_W + RECIP_W;
	localparam int Q_W    = PROD_W - DIV_SHIFT;

	logic [IN_W-1:0]   mag, mag_a;
	logic              neg_a;
	logic [PROD_W-1:0] prod_a;
	logic [Q_W-1:0]    q;
	logic signed [Q_W:0] qs;
	logic [IN_W+7:0]   q100;

	assign mag  = din[IN_W-1] ? IN_W'(-din) : IN_W'(din);
	assign q    = prod_a[PROD_W-1:DIV_SHIFT];
	assign qs   = neg_a ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign q100 = (IN_W+8)'(q) * (IN_W+8)'(DIV_BY);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_a  <= mag;
			neg_a  <= din[IN_W-1];
			prod_a <= {{RECIP_W{1'b0}}, mag} * {{IN_W{1'b0}}, DIV_RECIP};
		end
		if (en[1]) begin
			dout <= OUT_W'(qs);
		end
	end

	a_quot_exact: assert property (@(posedge clk) disable iff (!arst_n)
		vld_a |-> (q100 <= (IN_W+8)'(mag_a)) &&
		((IN_W+8)'(mag_a) - q100 < (IN_W+8)'(DIV_BY)))
		else $error("reciprocal quotient off by one");

endmodule

// File: rtl/core/baro_sensor_compensation.sv
`timescale 1ns / 1ps

// Compensates one raw pressure / raw temperature pair per request using six
// factory calibration words and returns pressure in whole millibar and
// temperature in whole degrees Celsius. The datapath is a ten-stage pipeline:
// a new request is taken every clock cycle unless back-pressure has filled the
// pipeline; its result is presented on the output from the last stage, and
// output back-pressure stalls only the stages that are occupied, so bubbles are
// squeezed out. The user must write calibration words through the cfg port while
// no request is in flight; the block does not enforce this. They reset to zero.
module baro_sensor_compensation #(
	parameter int ADC_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bsc_pkg::IN_TDATA_W-1:0]      s_tdata,  // pressure_raw, temperature_raw
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bsc_pkg::OUT_TDATA_W-1:0]     m_tdata,  // pressure_mbar, temperature_c, pad
	input  logic                                cfg_we,
	input  logic [bsc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [bsc_pkg::COEF_W-1:0]          cfg_data
);
	import bsc_pkg::*;

	localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

	coef_t                   coef_q;
	logic [NUM_STAGES-1:0]   vld_q;
	logic [NUM_STAGES:0]     rdy;
	stage_en_t               en;
	logic        [ADC_W-1:0] d1, d2, d1_s4;
	logic signed [OFF_W-1:0] off_s4;
	logic signed [SENS_W-1:0] sens_s4;
	logic signed [TQ_W-1:0]  tq_s4, tq_s8;
	logic signed [PQ_W-1:0]  pq_s8;
	logic signed [P_W-1:0]   press;
	logic signed [T_W-1:0]   temp;

	assign d1 = s_tdata[ADC_W-1:0] & ADC_MASK;
	assign d2 = s_tdata[2*ADC_W-1:ADC_W] & ADC_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENS_BASE:   coef_q.sens_base   <= cfg_data;
				REG_OFFSET_BASE: coef_q.offset_base <= cfg_data;
				REG_SENS_TEMP:   coef_q.sens_temp   <= cfg_data;
				REG_OFFSET_TEMP: coef_q.offset_temp <= cfg_data;
				REG_REF_TEMP:    coef_q.ref_temp    <= cfg_data;
				REG_TEMP_SLOPE:  coef_q.temp_slope  <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may load when it is empty or its successor moves on
	always_comb begin
		rdy[NUM_STAGES] = m_tready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign en       = rdy[NUM_STAGES-1:0];
	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	bsc_front u_front (
		.clk     (clk),
		.en      (en),
		.coef    (coef_q),
		.d1      (d1),
		.d2      (d2),
		.d1_s4   (d1_s4),
		.off_s4  (off_s4),
		.sens_s4 (sens_s4),
		.tq_s4   (tq_s4)
	);

	bsc_press u_press (
		.clk     (clk),
		.en      (en),
		.d1_s4   (d1_s4),
		.off_s4  (off_s4),
		.sens_s4 (sens_s4),
		.tq_s4   (tq_s4),
		.pq_s8   (pq_s8),
		.tq_s8   (tq_s8)
	);

	bsc_div100 #(
		.IN_W  (PQ_W),
		.OUT_W (P_W)
	) u_div_press (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[9:8]),
		.vld_a  (vld_q[8]),
		.din    (pq_s8),
		.dout   (press)
	);

	bsc_div100 #(
		.IN_W  (TQ_W),
		.OUT_W (T_W)
	) u_div_temp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[9:8]),
		.vld_a  (vld_q[8]),
		.din    (tq_s8),
		.dout   (temp)
	);

	assign m_tdata = {{(OUT_TDATA_W-P_W-T_W){1'b0}}, temp, press};

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(vld_q) == 0) |-> s_tready)
		else $error("empty pipeline refuses a request");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted request lost at first stage");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_TEMP_SLOPE) |=> coef_q.temp_slope == $past(cfg_data))
		else $error("calibration write not taken");

endmodule
